[design/sfm_pkg.sv]
// Shared types and constants for the SPI serial flash memory model.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package sfm_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 24;
    localparam int MASK_W = 18;
    localparam int POS_W  = 3;

    localparam logic [MASK_W-1:0] SIZE_MASK_RST = 18'h3FFFF;
    localparam logic [BYTE_W-1:0] ERASED_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] JEDEC_ID_BYTE = 8'hFF;

    // Byte position within a select: three address bytes, then data.
    localparam logic [POS_W-1:0] POS_ADDR_DONE = 3'd3;
    localparam logic [POS_W-1:0] POS_MAX       = 3'd4;

    // Command opcodes.
    localparam logic [BYTE_W-1:0] CMD_READ      = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_FAST_READ = 8'h0B;
    localparam logic [BYTE_W-1:0] CMD_PROGRAM   = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CMD_SECT_ERA  = 8'hD8;
    localparam logic [BYTE_W-1:0] CMD_PAGE_ERA  = 8'hDB;
    localparam logic [BYTE_W-1:0] CMD_JEDEC_ID  = 8'h9F;
    localparam logic [BYTE_W-1:0] CMD_RD_STATUS = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_WR_ENABLE = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_WR_DIS    = 8'h04;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_ERASE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_READ,
        ACT_RMW,
        ACT_WRITE,
        ACT_ERASE
    } t_act;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] read_data;
        logic              write_enabled;
    } t_result;

endpackage

[design/sfm_if.sv]
// Handshake channels of the SPI serial flash memory: input byte, result, configuration.
// Depends on sfm_pkg for field widths.
`timescale 1ns / 1ps

interface sfm_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfm_pkg::BYTE_W-1:0] spi_byte;
    logic                       hold_select;

    modport source (output valid, output spi_byte, output hold_select, input ready);
    modport sink   (input valid, input spi_byte, input hold_select, output ready);
endinterface

interface sfm_out_if;
    logic                       valid;
    logic                       ready;
    logic [sfm_pkg::BYTE_W-1:0] read_data;
    logic                       write_enabled;

    modport source (output valid, output read_data, output write_enabled, input ready);
    modport sink   (input valid, input read_data, input write_enabled, output ready);
endinterface

interface sfm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sfm_pkg::MASK_W-1:0] size_mask;

    modport source (output valid, output size_mask, input ready);
    modport sink   (input valid, input size_mask, output ready);
endinterface

[design/sfm_mem.sv]
// Flash byte store: single-port synchronous memory; read data is registered and ready in the cycle after the request.
// Depends on sfm_pkg for the request structure.
`timescale 1ns / 1ps

module sfm_mem #(
    parameter int MEM_BYTES = 262144
) (
    input  logic                       i_clk,
    input  sfm_pkg::t_mem_req          i_req,
    output logic [sfm_pkg::BYTE_W-1:0] o_rdata
);
    import sfm_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [BYTE_W-1:0] r_mem [MEM_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    // The address is reduced modulo the store size by dropping its upper bits.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/sfm_ctrl.sv]
// Command decoder and sequencer: byte protocol state, read-modify-write and erase sweeps.
// Depends on sfm_pkg and the channel interfaces in sfm_if.
`timescale 1ns / 1ps

module sfm_ctrl #(
    parameter int MEM_BYTES    = 262144,
    parameter int SECTOR_BYTES = 65536,
    parameter int PAGE_BYTES   = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sfm_in_if.sink                     i_in,
    input  logic [sfm_pkg::MASK_W-1:0] i_size_mask,
    output sfm_pkg::t_mem_req          o_req,
    input  logic [sfm_pkg::BYTE_W-1:0] i_rdata,
    output sfm_pkg::t_result           o_res,
    input  logic                       i_res_ready
);
    import sfm_pkg::*;

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SW  = $clog2(SECTOR_BYTES);
    localparam int PW  = $clog2(PAGE_BYTES);
    localparam int SPW = (SW > PW) ? SW : PW;
    localparam int CW  = (AW > SPW) ? AW : SPW;

    localparam logic [CW-1:0]     CLR_LAST  = CW'(MEM_BYTES - 1);
    localparam logic [CW-1:0]     SECT_LAST = CW'(SECTOR_BYTES - 1);
    localparam logic [CW-1:0]     PAGE_LAST = CW'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] SECT_OFS  = ADDR_W'(SECTOR_BYTES - 1);
    localparam logic [ADDR_W-1:0] PAGE_OFS  = ADDR_W'(PAGE_BYTES - 1);

    t_state r_state, n_state;

    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_out_reg, n_out;
    logic              r_wel, n_wel;
    logic              r_wrote, n_wrote;
    logic              r_sel, n_sel;
    logic [ADDR_W-1:0] r_base, n_base;
    logic              r_sector, n_sector;
    logic [ADDR_W-1:0] r_maddr;
    logic [BYTE_W-1:0] r_byte;
    logic              r_rmw;
    logic [CW-1:0]     r_cnt;

    t_act              act;
    logic              accept;
    logic [ADDR_W-1:0] mask24;
    logic [ADDR_W-1:0] addr_in;
    logic [ADDR_W-1:0] addr_take;
    logic [ADDR_W-1:0] addr_step;
    logic [POS_W-1:0]  pos_inc;
    logic [CW-1:0]     erase_last;

    assign accept     = i_in.valid && i_in.ready;
    assign mask24     = ADDR_W'(i_size_mask);
    assign addr_in    = {r_addr[ADDR_W-BYTE_W-1:0], i_in.spi_byte};
    assign pos_inc    = (r_pos < POS_MAX) ? r_pos + 3'd1 : r_pos;
    assign addr_take  = (pos_inc == POS_ADDR_DONE) ? (addr_in & mask24) : addr_in;
    assign addr_step  = (r_addr + 24'd1) & mask24;
    assign erase_last = r_sector ? SECT_LAST : PAGE_LAST;

    // Effect of one byte on the protocol state.
    always_comb begin : step
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_addr   = r_addr;
        n_out    = r_out_reg;
        n_wel    = r_wel;
        n_wrote  = r_wrote;
        n_base   = r_base;
        n_sector = r_sector;
        act      = ACT_NONE;
        if (!r_sel) begin
            n_cmd   = i_in.spi_byte;
            n_pos   = '0;
            n_addr  = '0;
            n_wrote = 1'b0;
            if (i_in.spi_byte == CMD_WR_DIS) begin
                n_wel = 1'b0;
            end else if (i_in.spi_byte == CMD_WR_ENABLE) begin
                n_wel = 1'b1;
            end
        end else begin
            case (r_cmd)
                CMD_READ, CMD_FAST_READ: begin
                    if (r_pos < POS_ADDR_DONE) begin
                        n_addr = addr_take;
                        n_pos  = pos_inc;
                    end else if (r_cmd == CMD_FAST_READ && r_pos == POS_ADDR_DONE) begin
                        n_pos = pos_inc;
                    end else begin
                        act    = ACT_READ;
                        n_addr = addr_step;
                        n_pos  = pos_inc;
                    end
                end
                CMD_PROGRAM, CMD_WRITE: begin
                    if (r_pos < POS_ADDR_DONE) begin
                        n_addr = addr_take;
                        n_pos  = pos_inc;
                    end else begin
                        if (r_wel) begin
                            act     = (r_cmd == CMD_PROGRAM) ? ACT_RMW : ACT_WRITE;
                            n_wrote = 1'b1;
                        end
                        n_addr = addr_step;
                        n_pos  = pos_inc;
                    end
                end
                CMD_SECT_ERA, CMD_PAGE_ERA: begin
                    if (r_pos < POS_ADDR_DONE) begin
                        n_addr = addr_take;
                        n_pos  = pos_inc;
                        if (pos_inc == POS_ADDR_DONE && r_wel) begin
                            act      = ACT_ERASE;
                            n_wrote  = 1'b1;
                            n_sector = (r_cmd == CMD_SECT_ERA);
                            n_base   = addr_take
                                     & ~((r_cmd == CMD_SECT_ERA) ? SECT_OFS : PAGE_OFS);
                        end
                    end
                end
                CMD_JEDEC_ID: begin
                    n_out = JEDEC_ID_BYTE;
                end
                CMD_RD_STATUS: begin
                    n_out = {6'b0, r_wel, 1'b0};
                end
                CMD_WR_ENABLE: begin
                    n_wel = 1'b1;
                end
                CMD_WR_DIS: begin
                    n_wel = 1'b0;
                end
                default: begin
                end
            endcase
        end
        // A select that wrote something drops the write enable latch as it ends.
        if (r_sel && !i_in.hold_select && n_wrote) begin
            n_wel = 1'b0;
        end
        n_sel = i_in.hold_select;
    end

    always_comb begin : next_state
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (act)
                        ACT_READ, ACT_RMW: n_state = ST_RDWAIT;
                        ACT_ERASE:         n_state = ST_ERASE;
                        default:           n_state = ST_EMIT;
                    endcase
                end
            end
            ST_RDWAIT: begin
                n_state = ST_EMIT;
            end
            ST_ERASE: begin
                if (r_cnt == erase_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin : outputs
        i_in.ready          = 1'b0;
        o_req.re            = 1'b0;
        o_req.we            = 1'b0;
        o_req.addr          = r_addr;
        o_req.wdata         = ERASED_BYTE;
        o_res.valid         = 1'b0;
        o_res.read_data     = r_out_reg;
        o_res.write_enabled = r_wel;
        case (r_state)
            ST_CLEAR: begin
                o_req.we   = 1'b1;
                o_req.addr = ADDR_W'(r_cnt);
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    o_req.re    = (act == ACT_READ) || (act == ACT_RMW);
                    o_req.we    = (act == ACT_WRITE);
                    o_req.wdata = i_in.spi_byte;
                end
            end
            ST_RDWAIT: begin
                // Second half of a program: the old byte is back, AND and store it; a read writes nothing here.
                o_req.we    = r_rmw;
                o_req.addr  = r_maddr;
                o_req.wdata = i_rdata & r_byte;
            end
            ST_ERASE: begin
                o_req.we   = 1'b1;
                o_req.addr = (r_base + ADDR_W'(r_cnt)) & mask24;
            end
            ST_EMIT: begin
                o_res.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cmd     <= '0;
            r_pos     <= '0;
            r_addr    <= '0;
            r_out_reg <= '0;
            r_wel     <= 1'b0;
            r_wrote   <= 1'b0;
            r_sel     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR || r_state == ST_ERASE) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == ST_IDLE && accept) begin
                r_cmd     <= n_cmd;
                r_pos     <= n_pos;
                r_addr    <= n_addr;
                r_out_reg <= n_out;
                r_wel     <= n_wel;
                r_wrote   <= n_wrote;
                r_sel     <= n_sel;
            end else if (r_state == ST_RDWAIT && !r_rmw) begin
                r_out_reg <= i_rdata;
            end
        end
    end

    // Operands held for the cycles after acceptance.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_base   <= n_base;
            r_sector <= n_sector;
            r_maddr  <= r_addr;
            r_byte   <= i_in.spi_byte;
            r_rmw    <= (act == ACT_RMW);
        end
    end

endmodule

[design/spi_serial_flash_memory.sv]
// Top level of the SPI serial flash memory model: configuration register, result register.
// Depends on sfm_pkg, sfm_if, sfm_mem and sfm_ctrl.
`timescale 1ns / 1ps

// Usage:
// Each transaction on i_in carries one SPI byte and hold_select, which says whether
// chip select stays asserted after it. The first byte after a deselect is the command.
// Every input transaction produces exactly one transaction on o_out with the held output
// byte and the write enable latch as they stand after that byte.
// i_cfg writes the address mask (flash size minus one); it is always ready and is meant
// to be written only while no byte is in flight.
// Timing: a byte that touches no memory goes from acceptance straight to the result state;
// a read or program byte first passes through a read-wait state, because the store is a
// synchronous memory with registered read data and program does a read-modify-write on it.
// A sector or page erase holds the input while it writes SECTOR_BYTES or PAGE_BYTES bytes,
// one byte per cycle. The result then reaches o_out through the output register once the
// sequencer finishes.
// Reset: after i_rst_n is released, the block sweeps all MEM_BYTES bytes of the store to 0xFF
// and accepts no byte until that sweep is done; configuration writes are taken.
// Stalls: o_out is a single output register. While it is full and not taken, the block
// still accepts and processes the next byte and then waits with that result until the
// register is freed, so no result is ever lost or reordered.
module spi_serial_flash_memory #(
    parameter int MEM_BYTES    = 262144,
    parameter int SECTOR_BYTES = 65536,
    parameter int PAGE_BYTES   = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfm_in_if.sink     i_in,
    sfm_cfg_if.sink    i_cfg,
    sfm_out_if.source  o_out
);
    import sfm_pkg::*;

    logic [MASK_W-1:0] r_size_mask;
    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    t_result           res;
    logic              res_ready;

    logic              r_ovalid;
    logic [BYTE_W-1:0] r_odata;
    logic              r_owel;

    // The mask register takes every write; the block does not check idleness.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mask <= SIZE_MASK_RST;
        end else if (i_cfg.valid) begin
            r_size_mask <= i_cfg.size_mask;
        end
    end

    sfm_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    sfm_ctrl #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_size_mask (r_size_mask),
        .o_req       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // The output register can load when it is empty or being emptied this cycle.
    assign res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_odata <= res.read_data;
            r_owel  <= res.write_enabled;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.read_data     = r_odata;
    assign o_out.write_enabled = r_owel;

endmodule
